FILE: rtl/core/wfha_pkg.sv
// ----------------------------------------------------------------------------
// wfha_pkg
// Shared types, codes and default sizes for the worst-fit hole allocator.
// ----------------------------------------------------------------------------
package wfha_pkg;

  // Default sizing of the hole table
  localparam int HOLES_DEF     = 16;
  localparam int SIZE_BITS_DEF = 16;

  // Fixed field widths on the channels
  localparam int CMD_W   = 2;
  localparam int HSIZE_W = 16;
  localparam int RSIZE_W = 16;
  localparam int STAT_W  = 2;
  localparam int CHOSE_W = 4;
  localparam int LEFT_W  = 16;
  localparam int FRAG_W  = 20;

  localparam logic [FRAG_W-1:0] FRAG_MAX = {FRAG_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_LOAD    = 2'd1,
    CMD_REQUEST = 2'd2,
    CMD_REPORT  = 2'd3
  } wfha_cmd_e;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // Hole marks kept next to the size in each table entry
  localparam int MARK_W = 2;
  localparam logic [MARK_W-1:0] MARK_FREE  = 2'd0;
  localparam logic [MARK_W-1:0] MARK_BUSY  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_ALLOC = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } wfha_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [HSIZE_W-1:0] hole_size;
    logic               hole_busy;
    logic [RSIZE_W-1:0] request_size;
  } wfha_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CHOSE_W-1:0] chosen_hole;
    logic [LEFT_W-1:0]  leftover;
    logic [FRAG_W-1:0]  external_frag;
    logic [FRAG_W-1:0]  internal_frag;
  } wfha_result_t;

endpackage

FILE: rtl/core/wfha_if.sv
// ----------------------------------------------------------------------------
// wfha_if
// Valid/ready channel interfaces for allocator commands and results.
// ----------------------------------------------------------------------------
interface wfha_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [wfha_pkg::CMD_W-1:0]    command;
  logic [wfha_pkg::HSIZE_W-1:0]  hole_size;
  logic                          hole_busy;
  logic [wfha_pkg::RSIZE_W-1:0]  request_size;

  modport source (output valid, command, hole_size, hole_busy, request_size,
                  input ready);
  modport sink   (input valid, command, hole_size, hole_busy, request_size,
                  output ready);
endinterface

interface wfha_res_if;
  logic                          valid;
  logic                          ready;
  logic [wfha_pkg::STAT_W-1:0]   status;
  logic [wfha_pkg::CHOSE_W-1:0]  chosen_hole;
  logic [wfha_pkg::LEFT_W-1:0]   leftover;
  logic [wfha_pkg::FRAG_W-1:0]   external_frag;
  logic [wfha_pkg::FRAG_W-1:0]   internal_frag;

  modport source (output valid, status, chosen_hole, leftover, external_frag,
                  internal_frag, input ready);
  modport sink   (input valid, status, chosen_hole, leftover, external_frag,
                  internal_frag, output ready);
endinterface

FILE: rtl/core/worst_fit_hole_allocator_core.sv
// ----------------------------------------------------------------------------
// worst_fit_hole_allocator_core
// Worst-fit allocator over a table of memory holes held in one memory.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_ch carries one command per transfer: clear, load a hole, request
//   space, or report fragmentation. res_ch returns exactly one result
//   transfer per command, in order.
//   Clear and load register their result and go straight to the done
//   state. A request or report walks the n loaded holes through the memory
//   read port, one entry per cycle; a granted request then adds a
//   write-back of the chosen hole before its result is offered. The
//   single read port sets the scan rate.
//   One command is in work at a time; the next is taken once the current
//   result has moved into the output register, even while that register
//   still waits for the receiver.
//   Reset empties the table (hole count zero) and drops any pending result;
//   memory contents are left as they are and never read before a load.
//   When the receiver stalls, the output register holds its result and the
//   sequencer holds the following one, so no result is lost.
// ----------------------------------------------------------------------------
module worst_fit_hole_allocator_core #(
  parameter int HOLES     = wfha_pkg::HOLES_DEF,
  parameter int SIZE_BITS = wfha_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  wfha_cmd_if.sink    cmd_ch,
  wfha_res_if.source  res_ch
);

  localparam int IDX_W = $clog2(HOLES);
  localparam int ENT_W = SIZE_BITS + wfha_pkg::MARK_W;

  wfha_pkg::wfha_cmd_t    cmd;
  wfha_pkg::wfha_result_t res;
  wfha_pkg::wfha_result_t out_res;
  logic                   out_valid;
  logic                   res_valid;
  logic                   res_ready;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [ENT_W-1:0]       mem_wdata;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_raddr;
  logic [ENT_W-1:0]       mem_rdata;

  // Pack the command payload
  assign cmd.command      = cmd_ch.command;
  assign cmd.hole_size    = cmd_ch.hole_size;
  assign cmd.hole_busy    = cmd_ch.hole_busy;
  assign cmd.request_size = cmd_ch.request_size;

  wfha_ctrl #(
    .HOLES     (HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_ch.valid),
    .cmd_ready (cmd_ch.ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  wfha_mem #(
    .DEPTH (HOLES),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: take a new result when empty or draining this cycle
  assign res_ready = !out_valid || res_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign res_ch.valid         = out_valid;
  assign res_ch.status        = out_res.status;
  assign res_ch.chosen_hole   = out_res.chosen_hole;
  assign res_ch.leftover      = out_res.leftover;
  assign res_ch.external_frag = out_res.external_frag;
  assign res_ch.internal_frag = out_res.internal_frag;

endmodule

FILE: rtl/core/wfha_mem.sv
// ----------------------------------------------------------------------------
// wfha_mem
// Hole table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wfha_mem #(
  parameter int DEPTH = wfha_pkg::HOLES_DEF,
  parameter int WIDTH = wfha_pkg::SIZE_BITS_DEF + wfha_pkg::MARK_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/wfha_ctrl.sv
// ----------------------------------------------------------------------------
// wfha_ctrl
// Command sequencer: loads holes, scans the table for worst fit or
// fragmentation sums, and writes the granted hole back.
// ----------------------------------------------------------------------------
module wfha_ctrl #(
  parameter int HOLES     = wfha_pkg::HOLES_DEF,
  parameter int SIZE_BITS = wfha_pkg::SIZE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  wfha_pkg::wfha_cmd_t               cmd,
  output logic                              res_valid,
  input  logic                              res_ready,
  output wfha_pkg::wfha_result_t            res,
  output logic                              mem_we,
  output logic [$clog2(HOLES)-1:0]          mem_waddr,
  output logic [SIZE_BITS+wfha_pkg::MARK_W-1:0] mem_wdata,
  output logic                              mem_re,
  output logic [$clog2(HOLES)-1:0]          mem_raddr,
  input  logic [SIZE_BITS+wfha_pkg::MARK_W-1:0] mem_rdata
);

  localparam int IDX_W = $clog2(HOLES);
  localparam int CNT_W = $clog2(HOLES + 1);
  localparam int CH_W  = (IDX_W > wfha_pkg::CHOSE_W) ? IDX_W : wfha_pkg::CHOSE_W;
  localparam int CMP_W = (SIZE_BITS > wfha_pkg::RSIZE_W) ? SIZE_BITS : wfha_pkg::RSIZE_W;
  localparam int ACC_W = (SIZE_BITS > wfha_pkg::FRAG_W) ? SIZE_BITS : wfha_pkg::FRAG_W;
  localparam int SUM_W = ACC_W + 1;

  function automatic logic [wfha_pkg::CHOSE_W-1:0] low_index(input logic [IDX_W-1:0] v);
    logic [CH_W-1:0] w;
    w = CH_W'(v);
    return w[wfha_pkg::CHOSE_W-1:0];
  endfunction

  function automatic logic [wfha_pkg::FRAG_W-1:0] sat_add(
    input logic [wfha_pkg::FRAG_W-1:0] acc,
    input logic [SIZE_BITS-1:0]        v
  );
    logic [SUM_W-1:0] s;
    s = SUM_W'(acc) + SUM_W'(v);
    if (s > SUM_W'(wfha_pkg::FRAG_MAX)) begin
      return wfha_pkg::FRAG_MAX;
    end
    return s[wfha_pkg::FRAG_W-1:0];
  endfunction

  wfha_pkg::wfha_state_e state, state_next;

  logic [CNT_W-1:0]           count;
  logic [wfha_pkg::CMD_W-1:0] op;
  logic [CMP_W-1:0]           req;
  logic [CNT_W-1:0]           rd_ptr;
  logic                       dv;
  logic [IDX_W-1:0]           tag;
  logic                       found;
  logic [IDX_W-1:0]           best;
  logic [SIZE_BITS-1:0]       best_left;
  logic [wfha_pkg::FRAG_W-1:0] ext_sum;
  logic [wfha_pkg::FRAG_W-1:0] int_sum;

  logic                       accept;
  logic                       full;
  logic                       scan_end;
  logic [SIZE_BITS-1:0]       hsize;
  logic [CMP_W-1:0]           hsize_ext;
  logic [SIZE_BITS-1:0]       e_space;
  logic [wfha_pkg::MARK_W-1:0] e_mark;
  logic [CMP_W-1:0]           e_diff;
  logic                       e_fits;
  logic [CMP_W-1:0]           left_ext;
  wfha_pkg::wfha_result_t     load_res;
  wfha_pkg::wfha_result_t     scan_res;

  assign accept    = cmd_valid && cmd_ready;
  assign full      = (count == CNT_W'(HOLES));
  assign scan_end  = (rd_ptr == count) && !dv;
  assign hsize_ext = CMP_W'(cmd.hole_size);
  assign hsize     = hsize_ext[SIZE_BITS-1:0];
  assign e_space   = mem_rdata[SIZE_BITS-1:0];
  assign e_mark    = mem_rdata[SIZE_BITS +: wfha_pkg::MARK_W];
  assign e_diff    = CMP_W'(e_space) - req;
  assign e_fits    = (e_mark == wfha_pkg::MARK_FREE) && (CMP_W'(e_space) >= req);
  assign left_ext  = CMP_W'(best_left);

  // Result of a load: slot written, or table full
  always_comb begin
    load_res = '0;
    if (full) begin
      load_res.status = wfha_pkg::STAT_FULL;
    end else begin
      load_res.chosen_hole = low_index(count[IDX_W-1:0]);
    end
  end

  // Result at the end of a scan
  always_comb begin
    scan_res = '0;
    if (op == wfha_pkg::CMD_REQUEST) begin
      if (found) begin
        scan_res.chosen_hole = low_index(best);
        scan_res.leftover    = left_ext[wfha_pkg::LEFT_W-1:0];
      end else begin
        scan_res.status = wfha_pkg::STAT_NOFIT;
      end
    end else begin
      scan_res.external_frag = ext_sum;
      scan_res.internal_frag = int_sum;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      wfha_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd.command == wfha_pkg::CMD_REQUEST ||
              cmd.command == wfha_pkg::CMD_REPORT) begin
            state_next = wfha_pkg::ST_SCAN;
          end else begin
            state_next = wfha_pkg::ST_DONE;
          end
        end
      end
      wfha_pkg::ST_SCAN: begin
        if (scan_end) begin
          if (op == wfha_pkg::CMD_REQUEST && found) begin
            state_next = wfha_pkg::ST_WRITE;
          end else begin
            state_next = wfha_pkg::ST_DONE;
          end
        end
      end
      wfha_pkg::ST_WRITE: begin
        state_next = wfha_pkg::ST_DONE;
      end
      wfha_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = wfha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wfha_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_ready = 1'b0;
    res_valid = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = count[IDX_W-1:0];
    mem_wdata = {(cmd.hole_busy ? wfha_pkg::MARK_BUSY : wfha_pkg::MARK_FREE), hsize};
    mem_re    = 1'b0;
    mem_raddr = rd_ptr[IDX_W-1:0];
    case (state)
      wfha_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        mem_we    = cmd_valid && (cmd.command == wfha_pkg::CMD_LOAD) && !full;
      end
      wfha_pkg::ST_SCAN: begin
        mem_re = (rd_ptr != count);
      end
      wfha_pkg::ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = best;
        mem_wdata = {wfha_pkg::MARK_ALLOC, best_left};
      end
      wfha_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wfha_pkg::ST_IDLE;
      count <= '0;
      dv    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        dv <= 1'b0;
        if (cmd.command == wfha_pkg::CMD_CLEAR) begin
          count <= '0;
        end else if (cmd.command == wfha_pkg::CMD_LOAD && !full) begin
          count <= count + CNT_W'(1);
        end
      end else if (state == wfha_pkg::ST_SCAN) begin
        dv <= mem_re;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= cmd.command;
      req       <= CMP_W'(cmd.request_size);
      rd_ptr    <= '0;
      found     <= 1'b0;
      best      <= '0;
      best_left <= '0;
      ext_sum   <= '0;
      int_sum   <= '0;
      if (cmd.command == wfha_pkg::CMD_LOAD) begin
        res <= load_res;
      end else begin
        res <= '0;
      end
    end else if (state == wfha_pkg::ST_SCAN) begin
      tag <= rd_ptr[IDX_W-1:0];
      if (mem_re) begin
        rd_ptr <= rd_ptr + CNT_W'(1);
      end
      if (dv) begin
        if (op == wfha_pkg::CMD_REQUEST) begin
          // Strictly larger leftover wins, so ties keep the lowest index
          if (e_fits && (!found || e_diff[SIZE_BITS-1:0] > best_left)) begin
            found     <= 1'b1;
            best      <= tag;
            best_left <= e_diff[SIZE_BITS-1:0];
          end
        end else begin
          if (e_mark == wfha_pkg::MARK_ALLOC) begin
            int_sum <= sat_add(int_sum, e_space);
          end else if (e_mark == wfha_pkg::MARK_FREE) begin
            ext_sum <= sat_add(ext_sum, e_space);
          end
        end
      end
      if (scan_end) begin
        res <= scan_res;
      end
    end
  end

endmodule
